// ----- src/qpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion product engine package
// Component format, opcodes and the Hamilton product term table.
// ----------------------------------------------------------------------------
package qpe_pkg;

    // Component format: signed fixed point.
    localparam int CW = 16;             // component width
    localparam int FB = 14;             // fraction bits
    localparam int PW = 2 * CW;         // width of one product
    localparam int SW = PW + 3;         // width of the four-term sum plus rounding
    localparam int RW = SW - FB;        // width after the fraction shift

    localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint ONE  = longint'(1) << FB;
    localparam longint HALF = longint'(1) << (FB - 1);

    typedef logic signed [CW-1:0] t_comp;
    typedef t_comp t_quat [4];

    // Identity scalar part, limited to the largest component.
    localparam t_comp ID_W = t_comp'((ONE > CMAX) ? CMAX : ONE);

    // Opcodes.
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_ERR  = 2'd1;
    localparam logic [1:0] OP_COMP = 2'd2;

    // For each result component: left index, right index and negate flag of
    // its four terms (component order w, x, y, z).
    localparam logic [1:0] HAM_L [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3}};
    localparam logic [1:0] HAM_R [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}};
    localparam logic HAM_N [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}};

endpackage

// ----- src/quaternion_product_engine.sv -----
// Path: an accepted input waits in the input register until the result register
// can load, then its result is registered there and offered at the output.
// Throughput: one item per cycle unless the output stalls; the compute stage
// (sixteen products, four sums, rounding and saturation) also closes the
// accumulator feedback loop. Reset: synchronous, active low; empties both
// stages and sets the running product to identity.
// ----------------------------------------------------------------------------
// Quaternion product engine
// Fixed-point Hamilton product, attitude error and running composition with
// rounding and saturation, one input register and one result register.
// ----------------------------------------------------------------------------
module quaternion_product_engine
    import qpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_opcode,
    input  logic                 i_restart,
    input  logic signed [CW-1:0] i_a_w,
    input  logic signed [CW-1:0] i_a_x,
    input  logic signed [CW-1:0] i_a_y,
    input  logic signed [CW-1:0] i_a_z,
    input  logic signed [CW-1:0] i_b_w,
    input  logic signed [CW-1:0] i_b_x,
    input  logic signed [CW-1:0] i_b_y,
    input  logic signed [CW-1:0] i_b_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [CW-1:0] o_res_w,
    output logic signed [CW-1:0] o_res_x,
    output logic signed [CW-1:0] o_res_y,
    output logic signed [CW-1:0] o_res_z,
    output logic                 o_clipped
);

    // Input stage registers.
    logic       r_in_valid;
    logic [1:0] r_op;
    logic       r_restart;
    t_quat      r_a;
    t_quat      r_b;

    // Running product.
    t_quat      r_acc;

    // Result registers.
    logic       r_out_valid;
    t_quat      r_res;
    logic       r_clip;

    // Compute stage signals.
    t_quat                 n_left;
    t_quat                 n_right;
    logic                  n_conj;
    logic signed [PW-1:0]  n_prod [4][4];
    logic signed [SW-1:0]  n_sum  [4];
    logic signed [SW-1:0]  n_rnd  [4];
    logic signed [RW-1:0]  n_shf  [4];
    t_quat                 n_res;
    logic [3:0]            n_sat;
    logic                  n_clip;

    logic out_load;
    logic advance;
    logic in_take;

    // Handshake: the result register loads when empty or when its transfer
    // completes; the input stage refills as it drains.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op      <= i_opcode;
            r_restart <= i_restart;
            r_a[0]    <= i_a_w;
            r_a[1]    <= i_a_x;
            r_a[2]    <= i_a_y;
            r_a[3]    <= i_a_z;
            r_b[0]    <= i_b_w;
            r_b[1]    <= i_b_x;
            r_b[2]    <= i_b_y;
            r_b[3]    <= i_b_z;
        end
    end

    // Operand selection: compose multiplies the accumulator (or identity on
    // restart) by the first operand.
    always_comb begin
        n_conj = (r_op == OP_ERR);
        if (r_op == OP_COMP) begin
            if (r_restart) begin
                n_left[0] = ID_W;
                n_left[1] = '0;
                n_left[2] = '0;
                n_left[3] = '0;
            end else begin
                n_left = r_acc;
            end
            n_right = r_a;
        end else begin
            n_left  = r_a;
            n_right = r_b;
        end
    end

    // Products and signed four-term sums. A conjugated operand flips the sign
    // of its term rather than the operand, so the most negative value is exact.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_sum[i] = '0;
            for (int t = 0; t < 4; t++) begin
                n_prod[i][t] = n_left[HAM_L[i][t]] * n_right[HAM_R[i][t]];
                if (HAM_N[i][t] ^ (n_conj && (HAM_R[i][t] != 2'd0))) begin
                    n_sum[i] = n_sum[i] - SW'(n_prod[i][t]);
                end else begin
                    n_sum[i] = n_sum[i] + SW'(n_prod[i][t]);
                end
            end
        end
    end

    // Round to nearest, drop the fraction bits and saturate.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_rnd[i] = n_sum[i] + SW'(HALF);
            n_shf[i] = n_rnd[i][SW-1:FB];
            n_sat[i] = !((&n_shf[i][RW-1:CW-1]) || !(|n_shf[i][RW-1:CW-1]));
            if (r_op == OP_MUL || r_op == OP_ERR || r_op == OP_COMP) begin
                if (n_sat[i]) begin
                    n_res[i] = n_shf[i][RW-1] ? t_comp'(CMIN) : t_comp'(CMAX);
                end else begin
                    n_res[i] = n_shf[i][CW-1:0];
                end
            end else begin
                n_res[i] = '0;
            end
        end
        n_clip = (r_op == OP_MUL || r_op == OP_ERR || r_op == OP_COMP) && (|n_sat);
    end

    // Running product update, taken when a compose item leaves the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0] <= ID_W;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_acc[3] <= '0;
        end else if (advance && r_op == OP_COMP) begin
            r_acc <= n_res;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res  <= n_res;
            r_clip <= n_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res_w     = r_res[0];
    assign o_res_x     = r_res[1];
    assign o_res_y     = r_res[2];
    assign o_res_z     = r_res[3];
    assign o_clipped   = r_clip;

endmodule

// ----- src/qpe_checker.sv -----
// ----------------------------------------------------------------------------
// Quaternion product engine checker
// Port-level assertions on handshake, reset and saturation behavior.
// ----------------------------------------------------------------------------
module qpe_checker
    import qpe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic signed [CW-1:0] o_res_w,
    input logic signed [CW-1:0] o_res_x,
    input logic signed [CW-1:0] o_res_y,
    input logic signed [CW-1:0] o_res_z,
    input logic                 o_clipped
);

    localparam t_comp SAT_HI = t_comp'(CMAX);
    localparam t_comp SAT_LO = t_comp'(CMIN);

    // A result held back by a stall stays offered.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_res_w) && $stable(o_res_x)
            && $stable(o_res_y) && $stable(o_res_z) && $stable(o_clipped))
        else $error("stalled result changed");

    // Reset leaves no result on offer.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // The input side only stalls when a finished result is held back.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A saturation flag comes with at least one component at a limit.
    a_clip_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            o_res_w == SAT_HI || o_res_w == SAT_LO || o_res_x == SAT_HI ||
            o_res_x == SAT_LO || o_res_y == SAT_HI || o_res_y == SAT_LO ||
            o_res_z == SAT_HI || o_res_z == SAT_LO)
        else $error("saturation flag without a saturated component");

endmodule

bind quaternion_product_engine qpe_checker u_qpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_res_w     (o_res_w),
    .o_res_x     (o_res_x),
    .o_res_y     (o_res_y),
    .o_res_z     (o_res_z),
    .o_clipped   (o_clipped)
);
